@@ hw/rtl/miq_pkg.sv @@
// ----------------------------------------------------------------------------
// miq_pkg: shared definitions for the middle insert queue
// Operation and status codes, default sizes and the decoded operation record.
// ----------------------------------------------------------------------------
package miq_pkg;

    // Default sizes.
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int ID_BITS_DEF     = 20;

    // Field widths fixed by the item layout.
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes; the high bit alone selects a remove.
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_PUSHED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    // Decoded operation, captured at the input transfer.
    typedef struct packed {
        logic                do_pop;        // read out the front-half head
        logic                do_rebalance;  // move back-half head to front-half tail
        logic                wr_front_id;   // write the new id at the front-half tail
        logic                wr_back_tail;  // write the new id at the back-half tail
        logic                wr_back_head;  // write the new id before the back-half head
        logic [STATUS_W-1:0] status;
    } op_t;

endpackage

@@ hw/rtl/middle_insert_queue_unit.sv @@
// ----------------------------------------------------------------------------
// middle_insert_queue_unit: queue with append, middle insert and head remove
// The queue is kept as a front-half FIFO and a back-half deque, each in its
// own synchronous memory, and is kept balanced after every operation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)            tuser
//  s_axis    in         item_id, zero fill            mode
//  m_axis    out        popped_id, occupancy, fill    status
//
//  An item's transfer cycle decodes the operation and reads the front-half
//  head and the back-half head; the commit step that follows writes the
//  memories, moves the pointers and loads the result register. The rebalance
//  step needs that read before the write. No new item is taken until commit.
//  Reset clears pointers and count; the memories need no clearing pass.
//  While the result register is full and not taken, the commit step waits.
//
module middle_insert_queue_unit
    import miq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // s_tdata: item_id, then zero fill
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [((ID_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: mode
    input  logic [MODE_W-1:0]   s_tuser,
    // m_tdata: popped_id, occupancy, then zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((ID_BITS + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // m_tuser: status
    output logic [STATUS_W-1:0] m_tuser
);

    localparam int HALF_DEPTH = (QUEUE_DEPTH + 1) / 2;
    localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int M_DATA_W   = ((ID_BITS + CNT_W + 7) / 8) * 8;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HALF_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Circular pointer steps.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    // Storage for the two halves.
    logic [ID_BITS-1:0] front_mem [HALF_DEPTH];
    logic [ID_BITS-1:0] back_mem  [HALF_DEPTH];

    logic               state_reg;
    logic [PTR_W-1:0]   front_head_reg;
    logic [PTR_W-1:0]   front_tail_reg;
    logic [PTR_W-1:0]   back_head_reg;
    logic [PTR_W-1:0]   back_tail_reg;
    logic [CNT_W-1:0]   count_reg;

    op_t                op_reg;
    op_t                op_next;
    logic [ID_BITS-1:0] id_reg;
    logic [CNT_W-1:0]   op_count_reg;
    logic [CNT_W-1:0]   op_count_next;

    logic [ID_BITS-1:0] front_rdata_reg;
    logic [ID_BITS-1:0] back_rdata_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_BITS-1:0]  out_popped_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic               in_xfer;
    logic               commit;
    logic [MODE_W-1:0]  mode;
    logic               front_we;
    logic [ID_BITS-1:0] front_wdata;
    logic               back_we;
    logic [PTR_W-1:0]   back_waddr;

    assign mode     = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // Decode the operation against the occupancy before it.
    always_comb
    begin
        op_next       = '0;
        op_count_next = count_reg;
        if (mode[1])
        begin
            if (count_reg == '0)
            begin
                op_next.status = STATUS_EMPTY;
            end
            else
            begin
                op_next.status       = STATUS_POPPED;
                op_next.do_pop       = 1'b1;
                op_next.do_rebalance = ~count_reg[0];
                op_count_next        = count_reg - 1'b1;
            end
        end
        else if (count_reg >= CNT_FULL)
        begin
            op_next.status = STATUS_FULL;
        end
        else
        begin
            op_next.status = STATUS_PUSHED;
            op_count_next  = count_reg + 1'b1;
            if (count_reg == '0)
            begin
                op_next.wr_front_id = 1'b1;
            end
            else if (mode == MODE_APPEND)
            begin
                op_next.do_rebalance = ~count_reg[0];
                op_next.wr_back_tail = 1'b1;
            end
            else if (count_reg[0])
            begin
                op_next.wr_back_head = 1'b1;
            end
            else
            begin
                op_next.wr_front_id = 1'b1;
            end
        end
    end

    // Memory write controls for the commit step.
    assign front_we    = commit && (op_reg.wr_front_id || op_reg.do_rebalance);
    assign front_wdata = op_reg.do_rebalance ? back_rdata_reg : id_reg;
    assign back_we     = commit && (op_reg.wr_back_tail || op_reg.wr_back_head);
    assign back_waddr  = op_reg.wr_back_head ? ptr_dec(back_head_reg) : back_tail_reg;

    // Front-half memory: read the head at the transfer, write the tail later.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            front_rdata_reg <= front_mem[front_head_reg];
        end
        if (front_we)
        begin
            front_mem[front_tail_reg] <= front_wdata;
        end
    end

    // Back-half memory: read the head at the transfer, write tail or head later.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            back_rdata_reg <= back_mem[back_head_reg];
        end
        if (back_we)
        begin
            back_mem[back_waddr] <= id_reg;
        end
    end

    // Captured identifier and resulting occupancy.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            id_reg       <= s_tdata[ID_BITS-1:0];
            op_count_reg <= op_count_next;
        end
    end

    // Sequencer, pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= '0;
            front_head_reg <= '0;
            front_tail_reg <= '0;
            back_head_reg  <= '0;
            back_tail_reg  <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg <= ST_EXEC;
                op_reg    <= op_next;
            end
            else if (commit)
            begin
                state_reg <= ST_IDLE;
                count_reg <= op_count_reg;
                if (op_reg.do_pop)
                begin
                    front_head_reg <= ptr_inc(front_head_reg);
                end
                if (front_we)
                begin
                    front_tail_reg <= ptr_inc(front_tail_reg);
                end
                if (op_reg.wr_back_head)
                begin
                    back_head_reg <= ptr_dec(back_head_reg);
                end
                else if (op_reg.do_rebalance)
                begin
                    back_head_reg <= ptr_inc(back_head_reg);
                end
                if (op_reg.wr_back_tail)
                begin
                    back_tail_reg <= ptr_inc(back_tail_reg);
                end
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= op_reg.status;
            out_popped_reg <= op_reg.do_pop ? front_rdata_reg : '0;
            out_count_reg  <= op_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_DATA_W'({out_count_reg, out_popped_reg});

endmodule

@@ bench/tb_middle_insert_queue_unit.sv @@
// ----------------------------------------------------------------------------
// tb_middle_insert_queue_unit: self-checking bench for the middle insert queue
// The bench drives append, middle insert and head remove operations with
// random gaps and random back-pressure. A behavioral copy of the two-half
// queue predicts status, popped id and occupancy for every transfer, and
// each result is checked against that prediction in order.
// ----------------------------------------------------------------------------
module tb_middle_insert_queue_unit;

    import miq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int ID_BITS     = ID_BITS_DEF;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int S_DATA_W    = ((ID_BITS + 7) / 8) * 8;
    localparam int M_DATA_W    = ((ID_BITS + OCC_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 5000;

    // Mode 3 is not named in the package; its high bit makes it a remove.
    localparam logic [MODE_W-1:0] MODE_REMOVE_ALT = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_BITS-1:0]  popped_id;
        logic [OCC_W-1:0]    occupancy;
    } queue_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // Predicted queue contents, split the same way the block splits them.
    logic [ID_BITS-1:0] front_ids[$];
    logic [ID_BITS-1:0] back_ids[$];
    queue_result_t      op_results_due[$];

    int error_count     = 0;
    int stall_cycles    = 0;
    int send_quiet_left = 0;
    int ready_hold      = 0;

    middle_insert_queue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int queue_fill();
        return front_ids.size() + back_ids.size();
    endfunction

    function automatic logic [ID_BITS-1:0] random_id();
        return ID_BITS'($urandom);
    endfunction

    function automatic logic [MODE_W-1:0] random_push_mode();
        return ($urandom_range(0, 1) == 0) ? MODE_APPEND : MODE_INSERT;
    endfunction

    // Apply one operation to the predicted queue and return its result.
    // The front half always keeps ceil(n/2) entries.
    function automatic queue_result_t apply_queue_op(input logic [MODE_W-1:0] mode,
                                                     input logic [ID_BITS-1:0] id);
        queue_result_t res;
        int            n;
        n = queue_fill();
        res.status    = STATUS_PUSHED;
        res.popped_id = '0;
        if (mode[1])
        begin
            if (n == 0)
                res.status = STATUS_EMPTY;
            else
            begin
                res.popped_id = front_ids[0];
                front_ids.delete(0);
                res.status    = STATUS_POPPED;
                // An odd count left means the front half is one short.
                if ((n - 1) % 2 == 1)
                begin
                    front_ids = {front_ids, back_ids[0]};
                    back_ids.delete(0);
                end
            end
        end
        else if (n >= QUEUE_DEPTH)
            res.status = STATUS_FULL;
        else if (n == 0)
            front_ids = {front_ids, id};
        else if (mode == MODE_APPEND)
        begin
            if (n % 2 == 0)
            begin
                front_ids = {front_ids, back_ids[0]};
                back_ids.delete(0);
            end
            back_ids = {back_ids, id};
        end
        else if (n % 2 == 1)
            back_ids = {id, back_ids};
        else
            front_ids = {front_ids, id};
        res.occupancy = OCC_W'(queue_fill());
        return res;
    endfunction

    // Send one operation after a random gap and predict its result once the
    // transfer has happened. Valid is left high so that a following call in
    // the same time step continues without a bubble.
    task automatic send_queue_op(input logic [MODE_W-1:0] mode,
                                 input logic [ID_BITS-1:0] id);
        int            gap;
        int            pick;
        queue_result_t res;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (send_quiet_left > 0)
            send_quiet_left = send_quiet_left - 1;
        else if (pick < 4)
            send_quiet_left = $urandom_range(20, 60);
        else if (pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_DATA_W'(id);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = apply_queue_op(mode, id);
        op_results_due = {op_results_due, res};
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (op_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Corner cases: empty removes, inserts at sizes 0, 2, 3 and 4, both remove codes.
    task automatic test_directed();
        send_queue_op(MODE_REMOVE, 20'h00000);
        send_queue_op(MODE_REMOVE_ALT, 20'hFFFFF);
        send_queue_op(MODE_INSERT, 20'hFFFFF);
        send_queue_op(MODE_APPEND, 20'h00000);
        send_queue_op(MODE_INSERT, 20'hA5A5A);
        send_queue_op(MODE_INSERT, 20'h5A5A5);
        send_queue_op(MODE_APPEND, 20'h00001);
        send_queue_op(MODE_APPEND, 20'h80000);
        send_queue_op(MODE_REMOVE, 20'h12345);
        send_queue_op(MODE_REMOVE_ALT, 20'h00000);
        send_queue_op(MODE_INSERT, 20'h7FFFF);
        send_queue_op(MODE_APPEND, 20'h12345);
        wait_for_results();
        // Drain with alternating remove codes, then remove once more on empty.
        while (queue_fill() > 0)
            send_queue_op(queue_fill() % 2 ? MODE_REMOVE : MODE_REMOVE_ALT, random_id());
        send_queue_op(MODE_REMOVE, 20'hFFFFF);
        wait_for_results();
    endtask

    // Mix slightly weighted to pushes that keeps the queue small.
    task automatic test_random_mix(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i == count / 2)
                wait_for_results();
            if (pick < 35)
                send_queue_op(MODE_APPEND, random_id());
            else if (pick < 60)
                send_queue_op(MODE_INSERT, random_id());
            else if (pick < 90)
                send_queue_op(MODE_REMOVE, random_id());
            else
                send_queue_op(MODE_REMOVE_ALT, random_id());
        end
        wait_for_results();
    endtask

    // Mostly pushes until the queue is full; the halves wrap on the way.
    task automatic test_fill_to_full();
        while (queue_fill() < QUEUE_DEPTH)
        begin
            if ($urandom_range(0, 99) < 10)
                send_queue_op(MODE_REMOVE, random_id());
            else
                send_queue_op(random_push_mode(), random_id());
        end
        wait_for_results();
    endtask

    // Pushes on a full queue are refused; one remove makes room for one push.
    task automatic test_push_on_full();
        for (int i = 0; i < 8; i++)
            send_queue_op(random_push_mode(), random_id());
        send_queue_op(MODE_REMOVE, random_id());
        send_queue_op(MODE_INSERT, random_id());
        send_queue_op(MODE_APPEND, random_id());
        send_queue_op(MODE_INSERT, random_id());
        wait_for_results();
    endtask

    // Remove-heavy traffic that drains part of the full queue.
    task automatic test_drain(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_queue_op(MODE_REMOVE, random_id());
            else if (pick < 80)
                send_queue_op(MODE_REMOVE_ALT, random_id());
            else
                send_queue_op(random_push_mode(), random_id());
        end
        wait_for_results();
    endtask

    // Receiver back-pressure: short ready and stall runs, some long ones.
    always @(posedge clk)
    begin : drive_ready
        int pick;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(20, 80);
            end
            else if (pick < 60)
            begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 3);
            end
            else if (pick < 93)
            begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(8, 40);
            end
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        queue_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tuser;
            got.popped_id = m_tdata[ID_BITS-1:0];
            got.occupancy = m_tdata[ID_BITS +: OCC_W];
            if (op_results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, status %0d popped_id %05h occupancy %0d",
                         $time, got.status, got.popped_id, got.occupancy);
            end
            else
            begin
                want = op_results_due[0];
                op_results_due.delete(0);
                if (got.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, got.status);
                end
                if (got.popped_id !== want.popped_id)
                begin
                    error_count++;
                    $display("%0t: popped_id mismatch, expected %05h, actual %05h",
                             $time, want.popped_id, got.popped_id);
                end
                if (got.occupancy !== want.occupancy)
                begin
                    error_count++;
                    $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                             $time, want.occupancy, got.occupancy);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Reset, run the tests in turn, then report.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix(250);
        test_fill_to_full();
        test_push_on_full();
        test_drain(400);
        wait_for_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
